// File: rtl/core/positional_list_engine_top_macros.svh
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define PLIST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check on every clock edge, reset included.
`define PLIST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PLIST_ASSERT(lbl, prop, msg)
`define PLIST_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/plist_pkg.sv
`timescale 1ns / 1ps
package plist_pkg;

    // List geometry
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request opcodes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } seq_state_t;

    // Sequencer strobes to the datapath
    typedef struct packed {
        logic exec;
        logic load;
    } seq_ctl_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              srch;
        logic [CMP_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] val;
    } cell_cmd_t;

endpackage

// File: rtl/core/positional_list_engine_top.sv
// After accept, the three-step sequencer has the cells update (exec step), then loads the
// result register (load step) once the output register is free. A new request is taken only
// once the last result is loaded, and a result waiting in the output register does not block it.
// Reset (aresetn, synchronous, active low) clears the count, sequencer and output valid;
// list entries are not cleared and hold garbage until written.
`timescale 1ns / 1ps
module positional_list_engine_top
    import plist_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_opcode,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_data,
    output logic signed [POS_W-1:0]  m_found_position,
    output logic [POS_W-1:0]         m_count
);

    `include "positional_list_engine_top_macros.svh"

    seq_ctl_t          ctl;
    logic              out_free;
    logic              accept;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [2:0]        op_reg;
    logic [CMP_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              modify_reg;
    logic              modify_next;
    logic [CMP_W-1:0]  pos_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [POS_W-1:0]  m_found_reg;
    logic [POS_W-1:0]  m_count_reg;

    logic [CMP_W-1:0]  pos_in;
    logic [CMP_W-1:0]  cnt_cmp;
    logic              list_full;

    cell_cmd_t         cmd;
    logic [DATA_W-1:0] entry_w [DEPTH];
    logic [DATA_W-1:0] rd_w    [DEPTH];
    logic [DEPTH-1:0]  hits;
    logic [DEPTH-1:0]  first_hit;
    logic [IDX_W-1:0]  found_idx;
    logic [CMP_W-1:0]  found_ext;
    logic [CMP_W-1:0]  count_ext;
    logic [DATA_W-1:0] rd_or;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    plist_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctl      (ctl)
    );

    // Decide status and target position at accept
    assign pos_in    = CMP_W'(s_position);
    assign cnt_cmp   = CMP_W'(count_reg);
    assign list_full = (cnt_cmp >= CMP_W'(DEPTH));

    always_comb begin
        status_next = ST_OK;
        modify_next = 1'b0;
        pos_next    = pos_in;
        case (s_opcode)
            OP_APPEND: begin
                pos_next = cnt_cmp;
                if (list_full) begin
                    status_next = ST_FULL;
                end else begin
                    modify_next = 1'b1;
                end
            end
            OP_INSERT: begin
                if (pos_in > cnt_cmp) begin
                    status_next = ST_RANGE;
                end else if (list_full) begin
                    status_next = ST_FULL;
                end else begin
                    modify_next = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos_in >= cnt_cmp) begin
                    status_next = ST_RANGE;
                end else begin
                    modify_next = 1'b1;
                end
            end
            OP_READ: begin
                if (pos_in >= cnt_cmp) begin
                    status_next = ST_RANGE;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // Hold the request
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_opcode;
            pos_reg    <= pos_next;
            val_reg    <= s_value;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modify_reg <= 1'b0;
        end else if (accept) begin
            modify_reg <= modify_next;
        end
    end

    // Broadcast command to the cells during the update cycle
    always_comb begin
        cmd.ins  = ctl.exec && modify_reg && ((op_reg == OP_APPEND) || (op_reg == OP_INSERT));
        cmd.del  = ctl.exec && modify_reg && (op_reg == OP_DELETE);
        cmd.srch = ctl.exec && (op_reg == OP_FIND);
        cmd.pos  = pos_reg;
        cmd.cnt  = count_reg;
        cmd.val  = val_reg;
    end

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = val_reg;
        end else begin : g_mid_l
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = entry_w[i];
        end else begin : g_mid_r
            assign right_w = entry_w[i+1];
        end

        plist_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .idx         (IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .rd_word     (rd_w[i]),
            .hit         (hits[i])
        );
    end

    // Combine the selected cell words
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | rd_w[i];
        end
    end

    // Capture read data and advance the count
    always_comb begin
        count_next = count_reg;
        if (ctl.exec && modify_reg) begin
            if (op_reg == OP_DELETE) begin
                count_next = count_reg - CNT_W'(1);
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.exec) begin
            rd_data_reg <= ((op_reg == OP_READ) && (status_reg == ST_OK)) ? rd_or : '0;
        end
    end

    // Pick the lowest matching cell
    assign first_hit = hits & (~hits + DEPTH'(1));

    always_comb begin
        found_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            found_idx = found_idx | (IDX_W'(i) & {IDX_W{first_hit[i]}});
        end
    end

    assign found_ext = CMP_W'(found_idx);
    assign count_ext = CMP_W'(count_reg);

    // Load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            m_data_reg  <= rd_data_reg;
            m_count_reg <= count_ext[POS_W-1:0];
            if (op_reg == OP_FIND) begin
                m_status_reg <= (|hits) ? ST_OK : ST_MISSING;
                m_found_reg  <= (|hits) ? found_ext[POS_W-1:0] : '1;
            end else begin
                m_status_reg <= status_reg;
                m_found_reg  <= '1;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_data           = m_data_reg;
    assign m_found_position = m_found_reg;
    assign m_count          = m_count_reg;

    `PLIST_ASSERT_ALWAYS(a_count_bound, (!aresetn || (count_reg <= CNT_W'(DEPTH))), "count exceeds depth")
    `PLIST_ASSERT(a_one_at_a_time, (accept |=> !s_ready), "request taken while busy")
    `PLIST_ASSERT(a_count_step, ((ctl.exec && modify_reg && (op_reg != OP_DELETE)) |=> (count_reg == $past(count_reg) + CNT_W'(1))), "count not advanced on insert")
    `PLIST_ASSERT(a_find_live, ((ctl.load && (op_reg == OP_FIND) && (|hits)) |-> (CNT_W'(found_idx) < count_reg)), "match outside live entries")
    `PLIST_ASSERT(a_no_overwrite, ((m_valid_reg && !m_ready) |-> !ctl.load), "result overwritten before taken")

endmodule

// File: rtl/core/plist_cell.sv
`timescale 1ns / 1ps
module plist_cell
    import plist_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IDX_W-1:0]  idx,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left_entry,
    input  logic [DATA_W-1:0] right_entry,
    output logic [DATA_W-1:0] entry,
    output logic [DATA_W-1:0] rd_word,
    output logic              hit
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              hit_reg;
    logic              hit_next;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  cnt_ext;

    assign idx_ext = CMP_W'(idx);
    assign cnt_ext = CMP_W'(cmd.cnt);

    // Shift up for insert, shift down for delete, else hold
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (idx_ext > cmd.pos) begin
                entry_next = left_entry;
            end else if (idx_ext == cmd.pos) begin
                entry_next = cmd.val;
            end
        end else if (cmd.del) begin
            if (idx_ext >= cmd.pos) begin
                entry_next = right_entry;
            end
        end
    end

    // Match only live entries
    always_comb begin
        hit_next = hit_reg;
        if (cmd.srch) begin
            hit_next = (entry_reg == cmd.val) && (idx_ext < cnt_ext);
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign entry   = entry_reg;
    assign hit     = hit_reg;
    assign rd_word = (idx_ext == cmd.pos) ? entry_reg : '0;

endmodule

// File: rtl/core/plist_seq.sv
`timescale 1ns / 1ps
module plist_seq
    import plist_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     out_free,
    output logic     s_ready,
    output seq_ctl_t ctl
);

    seq_state_t state_reg;
    seq_state_t state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready  = 1'b0;
        ctl.exec = 1'b0;
        ctl.load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_EXEC: begin
                ctl.exec = 1'b1;
            end
            S_OUT: begin
                ctl.load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sim/positional_list_engine_top_tb.sv
`timescale 1ns / 1ps
module positional_list_engine_top_tb;
    import plist_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int OP_TOP = (1 << 3) - 1;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic signed [POS_W-1:0]  found_position;
        logic [POS_W-1:0]         count;
    } list_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [2:0]               s_opcode = OP_APPEND;
    logic [POS_W-1:0]         s_position = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_data;
    logic signed [POS_W-1:0]  m_found_position;
    logic [POS_W-1:0]         m_count;

    // Shadow copy of the list
    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       list_len = 0;

    list_result_t pending_results [$];
    list_result_t want_result;
    int           error_count = 0;
    int           stall_cycles = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           hold_req_cnt = 0;
    int           hold_ack_cnt = 0;
    int           hold_left = 0;
    bit           grow_mode = 1'b1;

    positional_list_engine_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_data           (m_data),
        .m_found_position (m_found_position),
        .m_count          (m_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one request to the shadow list and return the result it yields
    function automatic list_result_t apply_request(logic [2:0] op, logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
        list_result_t r;
        int           p;
        int           i;
        bit           hit;
        p = int'(pos);
        hit = 1'b0;
        r.status = ST_OK;
        r.data = '0;
        r.found_position = '1;
        case (op)
            OP_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT: begin
                // range is checked ahead of fullness
                if (p > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (p >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_READ: begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    r.data = list_mem[p];
            end
            OP_FIND: begin
                r.status = ST_MISSING;
                for (i = 0; i < list_len; i++) begin
                    if (!hit && list_mem[i] == val) begin
                        hit = 1'b1;
                        r.found_position = POS_W'(i);
                        r.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        r.count = POS_W'(list_len);
        return r;
    endfunction

    // Mix of corner values and full-range values, with duplicates likely
    function automatic logic signed [DATA_W-1:0] random_value();
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(5))
                0: return '0;
                1: return '1;
                2: return {1'b1, {(DATA_W-1){1'b0}}};
                3: return {1'b0, {(DATA_W-1){1'b1}}};
                default: return DATA_W'($urandom_range(7));
            endcase
        end
        return $urandom();
    endfunction

    // Offer one request, hold it until taken, then record its expected result
    task automatic issue_request(logic [2:0] op, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_position <= pos;
        s_value <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.push_back(apply_request(op, pos, val));
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Empty list errors, corner values, duplicates and spare opcodes
    task automatic test_corner_requests();
        issue_request(OP_READ, 0, 0);
        issue_request(OP_DELETE, 0, 0);
        issue_request(OP_FIND, 0, 0);
        issue_request(OP_INSERT, 1, 5);
        issue_request(OP_INSERT, 0, {1'b0, {(DATA_W-1){1'b1}}});
        issue_request(OP_APPEND, '1, {1'b1, {(DATA_W-1){1'b0}}});
        issue_request(OP_INSERT, 1, 0);
        issue_request(OP_INSERT, 3, '1);
        issue_request(OP_APPEND, 0, '1);
        issue_request(OP_FIND, '1, '1);
        issue_request(OP_FIND, 0, {1'b1, {(DATA_W-1){1'b0}}});
        issue_request(OP_READ, 0, '1);
        issue_request(OP_READ, 4, 0);
        issue_request(OP_READ, 5, 0);
        issue_request(OP_READ, '1, 0);
        issue_request(OP_DELETE, '1, 0);
        issue_request(OP_DELETE, 0, 0);
        issue_request(OP_DELETE, 3, 0);
        issue_request(3'(int'(OP_FIND) + 1), POS_W'($urandom()), $urandom());
        issue_request(3'(OP_TOP - 1), POS_W'($urandom()), $urandom());
        issue_request(3'(OP_TOP), POS_W'($urandom()), $urandom());
        issue_request(OP_INSERT, POS_W'(DEPTH), 7);
        issue_request(OP_FIND, 0, 12345);
        issue_request(OP_DELETE, 1, 0);
    endtask

    // Grow to capacity, poke the full list, then empty it again
    task automatic test_fill_and_drain();
        int n;
        int k;
        n = DEPTH - list_len;
        for (k = 0; k < n; k++) begin
            if (k[0])
                issue_request(OP_INSERT, POS_W'($urandom_range(list_len, 0)), random_value());
            else
                issue_request(OP_APPEND, POS_W'($urandom()), random_value());
        end
        issue_request(OP_APPEND, 0, random_value());
        issue_request(OP_INSERT, POS_W'(DEPTH), random_value());
        issue_request(OP_INSERT, POS_W'(DEPTH + 1), random_value());
        issue_request(OP_READ, POS_W'(DEPTH - 1), 0);
        issue_request(OP_READ, POS_W'(DEPTH), 0);
        issue_request(OP_FIND, 0, list_mem[DEPTH-1]);
        issue_request(OP_DELETE, POS_W'(DEPTH - 1), 0);
        issue_request(OP_INSERT, 0, random_value());
        while (list_len > 0)
            issue_request(OP_DELETE, POS_W'($urandom_range(list_len - 1, 0)), 0);
        issue_request(OP_DELETE, 0, 0);
        issue_request(OP_APPEND, 0, random_value());
    endtask

    // Random requests with the fill level drifting between empty and full
    task automatic test_random_requests(int n);
        logic [2:0]               op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int                       r;
        int                       hi;
        int                       k;
        for (k = 0; k < n; k++) begin
            // steer toward the other end once a bound is reached
            if (list_len == DEPTH && $urandom_range(99) < 30)
                grow_mode = 1'b0;
            else if (list_len == 0 && $urandom_range(99) < 30)
                grow_mode = 1'b1;
            else if ($urandom_range(99) < 2)
                grow_mode = !grow_mode;
            r = $urandom_range(99);
            if (r < 3)
                op = 3'($urandom_range(OP_TOP, int'(OP_FIND) + 1));
            else if (r < 43)
                op = grow_mode ? ($urandom_range(1) ? OP_APPEND : OP_INSERT) : OP_DELETE;
            else if (r < 53)
                op = grow_mode ? OP_DELETE : ($urandom_range(1) ? OP_APPEND : OP_INSERT);
            else if (r < 78)
                op = OP_READ;
            else
                op = OP_FIND;
            hi = (op == OP_INSERT) ? list_len : list_len - 1;
            if (hi < 0)
                hi = 0;
            r = $urandom_range(99);
            if (r < 80)
                pos = POS_W'($urandom_range(hi, 0));
            else if (r < 90)
                pos = POS_W'(list_len + $urandom_range(2));
            else
                pos = POS_W'($urandom());
            if (op == OP_FIND && list_len > 0 && $urandom_range(99) < 60)
                val = list_mem[$urandom_range(list_len - 1, 0)];
            else
                val = random_value();
            issue_request(op, pos, val);
        end
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        int k;
        hold_req_cnt <= hold_req_cnt + 1;
        for (k = 0; k < 40; k++)
            issue_request($urandom_range(1) ? OP_APPEND : OP_READ,
                          POS_W'($urandom_range(list_len, 0)), random_value());
    endtask

    // Drive result-side ready: random idling or a long hold when requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no request pending: expected none, actual %h %h %h %h",
                         $time, m_status, m_data, m_found_position, m_count);
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                check_field("status", DATA_W'(want_result.status), DATA_W'(m_status));
                check_field("data", want_result.data, m_data);
                check_field("found_position",
                            DATA_W'(unsigned'(want_result.found_position)),
                            DATA_W'(unsigned'(m_found_position)));
                check_field("count", DATA_W'(want_result.count), DATA_W'(m_count));
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(17, 85);
        test_corner_requests();
        test_fill_and_drain();
        test_random_requests(300);

        set_idling(85, 17);
        test_random_requests(400);

        set_idling(0, 0);
        test_random_requests(400);
        test_output_backpressure();
        test_random_requests(100);

        // Drop valid, then let the last results drain
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
